/* hdl/aes_kx_pkg.sv */
// Shared constants, types, the S-box lookup table and the round constant function for the AES-128 key expansion.
`timescale 1ns / 1ps
package aes_kx_pkg;

  localparam int unsigned NumWords = 4;
  localparam logic [3:0] LastRound = 4'd10;

  typedef struct packed {
    logic load;
    logic step;
  } kx_cell_ctrl_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant used to step from round rnd to round rnd + 1.
  function automatic logic [7:0] rcon_of(input logic [3:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1b;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

/* hdl/aes_kx_if.sv */
// Valid/ready channel interfaces for cipher key and round key beats.
`timescale 1ns / 1ps
interface aes_kx_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_high;
  logic [63:0] key_low;

  modport source (output valid, output key_high, output key_low, input ready);
  modport sink (input valid, input key_high, input key_low, output ready);
endinterface

interface aes_kx_rk_if;
  logic        valid;
  logic        ready;
  logic [63:0] round_key_high;
  logic [63:0] round_key_low;
  logic [3:0]  round_index;
  logic        last_round;

  modport source (
    output valid, output round_key_high, output round_key_low,
    output round_index, output last_round, input ready
  );
  modport sink (
    input valid, input round_key_high, input round_key_low,
    input round_index, input last_round, output ready
  );
endinterface

/* hdl/aes128_key_expansion.sv */
// AES-128 key expansion: four chained word cells and a registered round key output.
// Round key 0 is taken into the word cells with the key beat and then registered at the output;
// after that one round key beat per cycle while rk_o.ready does not stall it, set by the single
// round step of the word cell chain; the next key is taken as round key 10 leaves the chain.
// Reset (rst_ni low, asynchronous) drops any run in progress and empties the output.
`timescale 1ns / 1ps
module aes128_key_expansion import aes_kx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  aes_kx_key_if.sink key_i,
  aes_kx_rk_if.source rk_o
);

  logic          busy_q, busy_d;
  logic [3:0]    rnd_q, rnd_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_high_q, out_low_q;
  logic [3:0]    out_idx_q;
  logic          out_last_q;
  logic          push;
  logic          key_take;
  kx_cell_ctrl_t cell_ctrl;
  logic [31:0]   load_word [NumWords];
  logic [31:0]   word      [NumWords];
  logic [31:0]   carry     [NumWords];
  logic [31:0]   mix;

  assign push     = busy_q && (!out_valid_q || rk_o.ready);
  assign key_i.ready = !busy_q || (push && (rnd_q == LastRound));
  assign key_take = key_i.valid && key_i.ready;

  assign cell_ctrl.load = key_take;
  assign cell_ctrl.step = push && (rnd_q != LastRound);

  assign load_word[0] = key_i.key_high[63:32];
  assign load_word[1] = key_i.key_high[31:0];
  assign load_word[2] = key_i.key_low[63:32];
  assign load_word[3] = key_i.key_low[31:0];

  aes_kx_sub_word u_sub_word (
    .word_i (word[NumWords-1]),
    .rnd_i  (rnd_q),
    .mix_o  (mix)
  );

  for (genvar i = 0; i < NumWords; i++) begin : g_cell
    aes_kx_word_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .load_word_i (load_word[i]),
      .carry_i     ((i == 0) ? mix : carry[(i == 0) ? 0 : i-1]),
      .word_o      (word[i]),
      .carry_o     (carry[i])
    );
  end

  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    if (push) begin
      if (rnd_q == LastRound) begin
        busy_d = 1'b0;
      end else begin
        rnd_d = rnd_q + 4'd1;
      end
    end
    if (key_take) begin
      busy_d = 1'b1;
      rnd_d  = 4'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rk_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rnd_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_high_q <= {word[0], word[1]};
      out_low_q  <= {word[2], word[3]};
      out_idx_q  <= rnd_q;
      out_last_q <= (rnd_q == LastRound);
    end
  end

  assign rk_o.valid          = out_valid_q;
  assign rk_o.round_key_high = out_high_q;
  assign rk_o.round_key_low  = out_low_q;
  assign rk_o.round_index    = out_idx_q;
  assign rk_o.last_round     = out_last_q;

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_o.valid |-> (rk_o.last_round == (rk_o.round_index == LastRound)))
    else $error("last_round flag does not match round index");

  a_key_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready) |=> (busy_q && (rnd_q == 4'd0)))
    else $error("key beat did not start a run at round 0");

  a_no_key_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (rnd_q != LastRound)) |-> !key_i.ready)
    else $error("key taken in the middle of a run");

  a_round_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rk_o.valid && rk_o.ready && !rk_o.last_round) |=>
      (rk_o.valid && (rk_o.round_index == 4'($past(rk_o.round_index) + 4'd1))))
    else $error("round keys not delivered back to back in order");

endmodule

/* hdl/aes_kx_sub_word.sv */
// RotWord, SubWord and round constant mix on the last word of a round key.
`timescale 1ns / 1ps
module aes_kx_sub_word import aes_kx_pkg::*; (
  input  logic [31:0] word_i,
  input  logic [3:0]  rnd_i,
  output logic [31:0] mix_o
);

  logic [31:0] rot;
  logic [31:0] sub;

  assign rot = {word_i[23:0], word_i[31:24]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      sub[b*8 +: 8] = Sbox[rot[b*8 +: 8]];
    end
  end

  assign mix_o = sub ^ {rcon_of(rnd_i), 24'h000000};

endmodule

/* hdl/aes_kx_word_cell.sv */
// One word cell of the key schedule chain: holds a word, folds in its neighbor.
`timescale 1ns / 1ps
module aes_kx_word_cell import aes_kx_pkg::*; (
  input  logic          clk_i,
  input  kx_cell_ctrl_t ctrl_i,
  input  logic [31:0]   load_word_i,
  input  logic [31:0]   carry_i,
  output logic [31:0]   word_o,
  output logic [31:0]   carry_o
);

  logic [31:0] word_q;
  logic [31:0] word_d;

  assign carry_o = word_q ^ carry_i;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = load_word_i;
    end else if (ctrl_i.step) begin
      word_d = carry_o;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* bench/tb_round_key_checker.sv */
// Watches the key and round key channels, predicts the AES-128 schedule and compares beats.
`timescale 1ns / 1ps
module tb_round_key_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  aes_kx_key_if  key_mon,
  aes_kx_rk_if   rk_mon,
  output int     fail_count_o,
  output int     pending_o,
  output int     keys_seen_o,
  output int     beats_seen_o
);

  localparam int NumRoundKeys = 11;

  localparam logic [7:0] SubByteLut [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RconLut [NumRoundKeys - 1] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [3:0]  index;
    logic        last;
  } round_key_t;

  round_key_t round_keys_due [$];
  int         fails;
  int         keys_seen;
  int         beats_seen;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want, input logic [3:0] idx);
    $display("[%0t] mismatch on %s at round %0d: got %h, want %h", $realtime, what, idx,
             got, want);
    fails++;
  endtask

  function automatic void expand_cipher_key(input logic [63:0] key_high,
                                            input logic [63:0] key_low);
    logic [31:0] w [4];
    logic [31:0] rot;
    logic [31:0] mix;
    round_key_t  rk;
    int          r;
    w[0] = key_high[63:32];
    w[1] = key_high[31:0];
    w[2] = key_low[63:32];
    w[3] = key_low[31:0];
    for (r = 0; r < NumRoundKeys; r++) begin
      if (r > 0) begin
        rot  = {w[3][23:0], w[3][31:24]};
        mix  = {SubByteLut[rot[31:24]], SubByteLut[rot[23:16]],
                SubByteLut[rot[15:8]], SubByteLut[rot[7:0]]};
        mix  = mix ^ {RconLut[r - 1], 24'h000000};
        w[0] = w[0] ^ mix;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
      end
      rk.key_high = {w[0], w[1]};
      rk.key_low  = {w[2], w[3]};
      rk.index    = 4'(r);
      rk.last     = (r == NumRoundKeys - 1);
      round_keys_due.push_back(rk);
    end
  endfunction

  always @(posedge clk_i) begin
    round_key_t want;
    if (rst_ni) begin
      // check the outgoing beat first: it never belongs to a key taken at this edge
      if (rk_mon.valid && rk_mon.ready) begin
        beats_seen++;
        if (round_keys_due.size() == 0) begin
          report_mismatch("unexpected beat", rk_mon.round_key_high, 64'h0,
                          rk_mon.round_index);
        end else begin
          want = round_keys_due.pop_front();
          if (rk_mon.round_key_high !== want.key_high)
            report_mismatch("round_key_high", rk_mon.round_key_high, want.key_high,
                            want.index);
          if (rk_mon.round_key_low !== want.key_low)
            report_mismatch("round_key_low", rk_mon.round_key_low, want.key_low,
                            want.index);
          if (rk_mon.round_index !== want.index)
            report_mismatch("round_index", 64'(rk_mon.round_index), 64'(want.index),
                            want.index);
          if (rk_mon.last_round !== want.last)
            report_mismatch("last_round", 64'(rk_mon.last_round), 64'(want.last),
                            want.index);
        end
      end
      if (key_mon.valid && key_mon.ready) begin
        keys_seen++;
        expand_cipher_key(key_mon.key_high, key_mon.key_low);
      end
    end
    fail_count_o <= fails;
    pending_o    <= round_keys_due.size();
    keys_seen_o  <= keys_seen;
    beats_seen_o <= beats_seen;
  end

endmodule

/* bench/tb_top.sv */
// Top of the key expansion bench: clock, reset, key stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int  RandomKeys    = 215;
  localparam int  HoldOffCycles = 300;
  localparam int  DrainCycles   = 20;
  localparam real TimeLimitNs   = 1000000.0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  aes_kx_key_if key_if ();
  aes_kx_rk_if  rk_if ();

  int fail_count;
  int pending;
  int keys_seen;
  int beats_seen;
  int hold_reqs = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  aes128_key_expansion dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .rk_o   (rk_if)
  );

  tb_round_key_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_mon      (key_if),
    .rk_mon       (rk_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .keys_seen_o  (keys_seen),
    .beats_seen_o (beats_seen)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [127:0] random_key();
    logic [127:0] one_hot;
    one_hot = 128'h1 << $urandom_range(0, 127);
    case ($urandom_range(0, 7))
      0:       return one_hot;
      1:       return ~one_hot;
      2:       return {16{8'($urandom)}};
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic drive_key(input logic [63:0] key_high, input logic [63:0] key_low,
                           input int gap);
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_if.valid    <= 1'b1;
    key_if.key_high <= key_high;
    key_if.key_low  <= key_low;
    do @(posedge clk_i); while (!key_if.ready);
  endtask

  task automatic wait_all_round_keys();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // output side: random gaps, calm stretches, and one long hold-off on request
  initial begin
    int idle_left;
    int calm_left;
    int hold_left;
    int hold_seen;
    idle_left = 0;
    calm_left = 0;
    hold_left = 0;
    hold_seen = 0;
    rk_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldOffCycles;
      end
      if (!rst_ni) begin
        rk_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rk_if.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rk_if.ready <= 1'b0;
      end else begin
        rk_if.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(50, 200);
        else if ($urandom_range(0, 2) == 0) idle_left = pick_gap();
      end
    end
  end

  initial begin
    logic [127:0] key;
    int           n;
    key_if.valid    <= 1'b0;
    key_if.key_high <= 64'h0;
    key_if.key_low  <= 64'h0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed keys: extremes, alternating bits, the standard test key
    drive_key(64'h0000000000000000, 64'h0000000000000000, 0);
    drive_key(64'hffffffffffffffff, 64'hffffffffffffffff, 0);
    drive_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 0);
    drive_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, pick_gap());
    drive_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, pick_gap());
    drive_key(64'hffffffffffffffff, 64'h0000000000000000, 0);
    drive_key(64'h0000000000000000, 64'hffffffffffffffff, pick_gap());
    drive_key(64'h8000000000000000, 64'h0000000000000001, 0);
    drive_key(64'h000102030405060a, 64'h08090a0b0c0d0e0f, 0);
    drive_key(64'h0123456789abcdef, 64'hfedcba9876543210, 3);
    drive_key(64'h0000000000000000, 64'h00000000ffffffff, 1);
    drive_key(64'hffffffff00000000, 64'h0000000000000000, 0);
    drive_key(64'h5252525252525252, 64'h5252525252525252, 0);
    drive_key(64'h6363636363636363, 64'h6363636363636363, 2);
    drive_key(64'h7fffffffffffffff, 64'hfffffffffffffffe, 0);

    // idle the key side until every round key has come out
    key_if.valid <= 1'b0;
    wait_all_round_keys();

    for (n = 0; n < RandomKeys; n++) begin
      key = random_key();
      if (n == RandomKeys / 2) hold_reqs <= hold_reqs + 1;
      if (n == (3 * RandomKeys) / 4) begin
        key_if.valid <= 1'b0;
        wait_all_round_keys();
      end
      drive_key(key[127:64], key[63:0], pick_gap());
    end
    key_if.valid <= 1'b0;

    wait_all_round_keys();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Expanded %0d cipher keys into %0d round key beats under random gaps,",
             keys_seen, beats_seen);
    $display("a long output hold-off and idle pauses on the key side.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("Timeout with %0d round keys still pending.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hdl/aes_kx_pkg.sv
hdl/aes_kx_if.sv
hdl/aes_kx_sub_word.sv
hdl/aes_kx_word_cell.sv
hdl/aes128_key_expansion.sv
bench/tb_round_key_checker.sv
bench/tb_top.sv
